### rtl/frt_pkg.sv
// frt_pkg: shared types and constants for the fragment reassembly tracker
// no dependencies
`default_nettype none
package frt_pkg;
    localparam int MAX_FRAGMENTS = 256;
    localparam int STORE_BYTES   = 4096;
    localparam int MAP_AW        = $clog2(MAX_FRAGMENTS);
    localparam int STORE_AW      = $clog2(STORE_BYTES);
    localparam int CNT_W         = 9;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] REG_MFS = 2'd0;

    localparam logic [1:0] KIND_FRAG  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_WRONG_ID = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_SIZE     = 3'd3;
    localparam logic [2:0] ST_DUP      = 3'd4;
    localparam logic [2:0] ST_TOO_BIG  = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  msg_id;
        logic [15:0] frag_index;
        logic [7:0]  frag_size;
        logic [15:0] total_size;
        logic [7:0]  byte_offset;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [11:0] read_address;
        logic [CNT_W-1:0] cnt;     // ceil(total/mfs), truncated to CNT_W bits
        logic        cnt_big;      // count above MAX_FRAGMENTS
        logic [7:0]  mfs;
    } frt_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        message_done;
        logic [8:0]  missing_fragments;
        logic [7:0]  read_data;
        logic [15:0] message_bytes;
    } frt_result_t;

    typedef enum logic [1:0] {
        FS_IDLE, FS_DIV, FS_PUSH
    } frt_front_state_t;

    typedef enum logic [1:0] {
        BS_EXEC, BS_READ, BS_OUT
    } frt_back_state_t;
endpackage
`default_nettype wire

### rtl/frt_ram.sv
// frt_ram: generic single port ram with registered read
// no dependencies
`default_nettype none
module frt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  addr,
    input  wire [WIDTH-1:0]          wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/frt_front.sv
// frt_front: accepts input beats and computes fragment count for offset-0 fragment beats
// depends on frt_pkg
`default_nettype none
module frt_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire frt_pkg::frt_item_t in_item,
    output logic                 q_push,
    input  wire                  q_full,
    output frt_pkg::frt_item_t   q_item
);
    frt_pkg::frt_front_state_t state_reg, state_next;
    frt_pkg::frt_item_t item_reg, item_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [4:0]  bit_reg, bit_next;
    logic [16:0] trial;
    logic [16:0] rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frt_pkg::FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        item_reg <= item_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
    end

    // restoring division, one quotient bit a cycle
    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        in_ready   = 1'b0;
        q_push     = 1'b0;
        q_item     = item_reg;
        rem_sh     = {rem_reg[15:0], item_reg.total_size[bit_reg[3:0]]};
        trial      = rem_sh - {9'd0, item_reg.mfs};
        case (state_reg)
            frt_pkg::FS_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next = in_item;
                    if (in_item.mfs == 8'd0) begin
                        item_next.mfs = 8'd1;
                    end
                    rem_next = '0;
                    quo_next = '0;
                    bit_next = 5'd15;
                    if (in_item.kind == frt_pkg::KIND_FRAG
                        && in_item.byte_offset == 8'd0) begin
                        state_next = frt_pkg::FS_DIV;
                    end else begin
                        state_next = frt_pkg::FS_PUSH;
                    end
                end
            end
            frt_pkg::FS_DIV: begin
                if (!trial[16]) begin
                    rem_next = trial;
                    quo_next = {quo_reg[15:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0) begin
                    state_next = frt_pkg::FS_PUSH;
                end
            end
            frt_pkg::FS_PUSH: begin
                q_item.cnt_big = (quo_reg + {16'd0, rem_reg != 17'd0})
                                 > 17'(frt_pkg::MAX_FRAGMENTS);
                q_item.cnt = 9'(quo_reg + {16'd0, rem_reg != 17'd0});
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = frt_pkg::FS_IDLE;
                end
            end
            default: state_next = frt_pkg::FS_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/frt_queue.sv
// frt_queue: short fifo between front and back
// depends on frt_pkg
`default_nettype none
module frt_queue (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  wire frt_pkg::frt_item_t push_item,
    output logic                 full,
    input  wire                  pop,
    output logic                 empty,
    output frt_pkg::frt_item_t   head
);
    frt_pkg::frt_item_t slot_reg [frt_pkg::QUEUE_DEPTH];
    logic wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'(frt_pkg::QUEUE_DEPTH);
    assign empty = count_reg == 2'd0;
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) slot_reg[wptr_reg] <= push_item;
    end
endmodule
`default_nettype wire

### rtl/frt_back.sv
// frt_back: session checks, received map, store writes and result register
// depends on frt_pkg, frt_ram
`default_nettype none
module frt_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_empty,
    input  wire frt_pkg::frt_item_t q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire                  out_ready,
    output frt_pkg::frt_result_t out_res
);
    frt_pkg::frt_back_state_t state_reg, state_next;
    logic        open_reg, open_next;
    logic [7:0]  sid_reg, sid_next;
    logic [15:0] sbytes_reg, sbytes_next;
    logic [8:0]  ftot_reg, ftot_next;
    logic [8:0]  miss_reg, miss_next;
    logic [2:0]  verd_reg, verd_next;
    logic [15:0] base_reg, base_next;
    logic [frt_pkg::MAX_FRAGMENTS-1:0] map_reg, map_next;
    frt_pkg::frt_result_t res_reg, res_next;
    logic        rd_zero_reg, rd_zero_next;

    logic        we;
    logic [frt_pkg::STORE_AW-1:0] addr;
    logic [7:0]  rdata;
    logic        opening;
    logic [7:0]  c_id;
    logic [8:0]  c_tot;
    logic [2:0]  code;
    logic [15:0] c_base;
    logic [15:0] waddr;
    logic [23:0] prod;

    frt_ram #(.WIDTH(8), .DEPTH(frt_pkg::STORE_BYTES)) u_store (
        .aclk(aclk), .we(we), .addr(addr), .wdata(q_head.data_byte), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= frt_pkg::BS_EXEC;
            open_reg   <= 1'b0;
            sid_reg    <= '0;
            sbytes_reg <= '0;
            ftot_reg   <= '0;
            miss_reg   <= '0;
            verd_reg   <= '0;
            base_reg   <= '0;
            map_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            open_reg   <= open_next;
            sid_reg    <= sid_next;
            sbytes_reg <= sbytes_next;
            ftot_reg   <= ftot_next;
            miss_reg   <= miss_next;
            verd_reg   <= verd_next;
            base_reg   <= base_next;
            map_reg    <= map_next;
        end
        res_reg     <= res_next;
        rd_zero_reg <= rd_zero_next;
    end

    assign out_valid = state_reg == frt_pkg::BS_OUT;
    assign out_res   = res_reg;

    always_comb begin
        state_next  = state_reg;
        open_next   = open_reg;
        sid_next    = sid_reg;
        sbytes_next = sbytes_reg;
        ftot_next   = ftot_reg;
        miss_next   = miss_reg;
        verd_next   = verd_reg;
        base_next   = base_reg;
        map_next    = map_reg;
        res_next    = res_reg;
        rd_zero_next = rd_zero_reg;
        q_pop = 1'b0;
        we    = 1'b0;
        addr  = q_head.read_address[frt_pkg::STORE_AW-1:0];
        opening = !open_reg || miss_reg == 9'd0;
        c_id  = opening ? q_head.msg_id : sid_reg;
        c_tot = opening ? q_head.cnt : ftot_reg;
        prod  = q_head.frag_index * q_head.mfs;
        c_base = prod[15:0];
        code  = frt_pkg::ST_OK;
        if (q_head.msg_id != c_id) code = frt_pkg::ST_WRONG_ID;
        else if (q_head.frag_index >= {7'd0, c_tot}) code = frt_pkg::ST_RANGE;
        else if (q_head.frag_index != {7'd0, c_tot} - 16'd1
                 && q_head.frag_size != q_head.mfs) code = frt_pkg::ST_SIZE;
        else if (!opening && map_reg[q_head.frag_index[frt_pkg::MAP_AW-1:0]])
            code = frt_pkg::ST_DUP;
        waddr = base_reg + {8'd0, q_head.byte_offset};
        case (state_reg)
            frt_pkg::BS_EXEC: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        frt_pkg::KIND_READ: begin
                            rd_zero_next = 1'b0;
                            state_next = frt_pkg::BS_READ;
                        end
                        frt_pkg::KIND_ABORT: begin
                            open_next = 1'b0; sid_next = '0; sbytes_next = '0;
                            ftot_next = '0; miss_next = '0; verd_next = '0;
                            base_next = '0; map_next = '0;
                            res_next = '0;
                            state_next = frt_pkg::BS_OUT;
                        end
                        frt_pkg::KIND_FRAG: begin
                            if (q_head.byte_offset == 8'd0) begin
                                if (opening && (q_head.cnt_big
                                    || q_head.total_size > 16'(frt_pkg::STORE_BYTES))) begin
                                    verd_next = frt_pkg::ST_TOO_BIG;
                                end else begin
                                    verd_next = code;
                                    if (code == frt_pkg::ST_OK) begin
                                        if (opening) begin
                                            map_next = '0;
                                            open_next = 1'b1;
                                            sid_next = c_id;
                                            sbytes_next = q_head.total_size;
                                            ftot_next = c_tot;
                                        end
                                        map_next[q_head.frag_index[frt_pkg::MAP_AW-1:0]] = 1'b1;
                                        base_next = c_base;
                                        miss_next = (opening ? c_tot : miss_reg) - 9'd1;
                                    end
                                end
                                waddr = base_next + {8'd0, q_head.byte_offset};
                            end
                            if (open_next && verd_next == frt_pkg::ST_OK
                                && q_head.byte_offset < q_head.frag_size
                                && waddr < sbytes_next
                                && waddr < 16'(frt_pkg::STORE_BYTES)) begin
                                we = 1'b1;
                                addr = waddr[frt_pkg::STORE_AW-1:0];
                            end
                            if (q_head.last_byte) begin
                                res_next.status = verd_next;
                                res_next.message_done = open_next && miss_next == 9'd0;
                                res_next.missing_fragments = miss_next;
                                res_next.read_data = 8'd0;
                                res_next.message_bytes = sbytes_next;
                                state_next = frt_pkg::BS_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            frt_pkg::BS_READ: begin
                res_next.status = verd_reg;
                res_next.message_done = open_reg && miss_reg == 9'd0;
                res_next.missing_fragments = miss_reg;
                res_next.read_data = rd_zero_reg ? 8'd0 : rdata;
                res_next.message_bytes = sbytes_reg;
                state_next = frt_pkg::BS_OUT;
            end
            frt_pkg::BS_OUT: begin
                if (out_ready) state_next = frt_pkg::BS_EXEC;
            end
            default: state_next = frt_pkg::BS_EXEC;
        endcase
    end
endmodule
`default_nettype wire

### rtl/fragment_reassembly_tracker_top.sv
// fragment_reassembly_tracker_top: front divider, item queue and back executor
// depends on frt_pkg, frt_front, frt_queue, frt_back
// front: idle, then 16-step divider for offset-0 fragment beats, then push; one beat at a time
// back executes a beat per cycle while no result beat is pending; readback adds a read state (store read port)
// result beat is held in the output state until taken; the back pops no beat meanwhile
// reset: synchronous active-low aresetn clears session state and map; store is not cleared
`default_nettype none
module fragment_reassembly_tracker_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_tvalid,
    output logic        s_tready,
    // lsb up: kind[1:0] msg_id[9:2] frag_index[25:10] frag_size[33:26]
    // total_size[49:34] byte_offset[57:50] data_byte[65:58] read_address[77:66]
    input  wire  [79:0] s_tdata,
    input  wire         s_tlast,     // last_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    // lsb up: status[2:0] message_done[3] missing_fragments[12:4] read_data[20:13]
    // message_bytes[36:21]
    output logic [39:0] m_tdata
);
    logic [7:0] mfs_reg;
    frt_pkg::frt_item_t in_item, q_in, q_head;
    frt_pkg::frt_result_t res;
    logic q_push, q_full, q_pop, q_empty;

    // configuration register, only address 0 exists
    assign pready = 1'b1;
    assign prdata = (paddr == frt_pkg::REG_MFS) ? {24'd0, mfs_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mfs_reg <= 8'd200;
        end else if (psel && penable && pwrite && paddr == frt_pkg::REG_MFS) begin
            mfs_reg <= pwdata[7:0];
        end
    end

    // unpack input beat
    always_comb begin
        in_item = '0;
        in_item.kind         = s_tdata[1:0];
        in_item.msg_id       = s_tdata[9:2];
        in_item.frag_index   = s_tdata[25:10];
        in_item.frag_size    = s_tdata[33:26];
        in_item.total_size   = s_tdata[49:34];
        in_item.byte_offset  = s_tdata[57:50];
        in_item.data_byte    = s_tdata[65:58];
        in_item.last_byte    = s_tlast;
        in_item.read_address = s_tdata[77:66];
        in_item.mfs          = mfs_reg;
    end

    frt_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_push(q_push), .q_full(q_full), .q_item(q_in)
    );

    frt_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_item(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .head(q_head)
    );

    frt_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {3'd0, res.message_bytes, res.read_data, res.missing_fragments,
                      res.message_done, res.status};
endmodule
`default_nettype wire
